[rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion, checked during reset as well.
`define ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/skt_pkg.sv]
// Types, constants and saturating helpers for the scalar Kalman tracker.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int DATA_W    = 32;
    localparam int COV_W     = 31;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS_GAIN_T = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIFT_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OBS_GAIN_T   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_NOISE   = 3'd6;

    localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
    localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef struct packed {
        logic  en;
        data_t op_a;
        data_t op_b;
    } mul_req_t;

    typedef struct packed {
        logic             start;
        data_t            num;
        logic [COV_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic  busy;
        data_t quot;
    } div_rsp_t;

    function automatic data_t sat_add(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    function automatic data_t sat_sub(input data_t a, input data_t b);
        logic signed [DATA_W:0] s;
        s = {a[DATA_W-1], a} - {b[DATA_W-1], b};
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? SAT_MIN : SAT_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

[rtl/scalar_kalman_tracker.sv]
// Top level of the scalar Kalman tracker: sequencer, state, config and output register.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_mode, s_sample, s_init_cov, s_init_pred_cov
//   m_        out        m_valid / m_ready      m_current, m_predicted, m_div_fault
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each item runs ten multiplies on the shared multiplier (ST_MUL, then ST_WB) and,
// after the innovation step, the divider (ST_DIVGO, ST_DIVWAIT) at two quotient
// bits per cycle; a non-positive denominator skips the divider. s_ready returns once
// the result is loaded into the output register. A result waiting there stalls the
// next item only in ST_FIN. Reset is synchronous and loads the sequencer, config,
// state and m_valid registers; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module scalar_kalman_tracker #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_mode,
    input  wire logic signed [skt_pkg::DATA_W-1:0] s_sample,
    input  wire logic [skt_pkg::COV_W-1:0]         s_init_cov,
    input  wire logic [skt_pkg::COV_W-1:0]         s_init_pred_cov,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [skt_pkg::DATA_W-1:0]      m_current,
    output logic signed [skt_pkg::DATA_W-1:0]      m_predicted,
    output logic                                   m_div_fault,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [skt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [skt_pkg::DATA_W-1:0]        cfg_data
);

    localparam logic [skt_pkg::DATA_W-1:0] ONE = skt_pkg::DATA_W'(64'd1 << FRAC_BITS);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_WB      = 3'd2;
    localparam logic [2:0] ST_DIVGO   = 3'd3;
    localparam logic [2:0] ST_DIVWAIT = 3'd4;
    localparam logic [2:0] ST_FIN     = 3'd5;

    localparam logic [3:0] OP_PPHT  = 4'd0;
    localparam logic [3:0] OP_HPP   = 4'd1;
    localparam logic [3:0] OP_DEN   = 4'd2;
    localparam logic [3:0] OP_INNOV = 4'd3;
    localparam logic [3:0] OP_EST   = 4'd4;
    localparam logic [3:0] OP_IKH   = 4'd5;
    localparam logic [3:0] OP_COV   = 4'd6;
    localparam logic [3:0] OP_PRED  = 4'd7;
    localparam logic [3:0] OP_AP    = 4'd8;
    localparam logic [3:0] OP_PPRED = 4'd9;

    logic [2:0] state_reg, state_next;
    logic [3:0] step_reg, step_next;

    skt_pkg::data_t a_reg, at_reg, b_reg, h_reg, ht_reg;
    logic [skt_pkg::COV_W-1:0] r_reg, q_reg;

    skt_pkg::data_t x_reg, xp_reg, p_reg, pp_reg;
    skt_pkg::data_t obs_reg, ppht_reg, tmp_reg, den_reg, innov_reg, gain_reg;
    logic           fault_reg;

    logic           m_valid_reg, m_valid_next;
    skt_pkg::data_t m_current_reg, m_predicted_reg;
    logic           m_div_fault_reg;

    skt_pkg::mul_req_t mul_req;
    skt_pkg::data_t    mul_res;
    skt_pkg::div_req_t div_req;
    skt_pkg::div_rsp_t div_rsp;

    logic accept;
    logic den_pos;
    logic fin_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign den_pos   = !den_reg[skt_pkg::DATA_W-1] && (den_reg != '0);
    assign fin_load  = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    skt_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .res  (mul_res)
    );

    skt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        mul_req.en = (state_reg == ST_MUL);
        case (step_reg)
            OP_PPHT:  begin mul_req.op_a = pp_reg;   mul_req.op_b = ht_reg;    end
            OP_HPP:   begin mul_req.op_a = h_reg;    mul_req.op_b = pp_reg;    end
            OP_DEN:   begin mul_req.op_a = tmp_reg;  mul_req.op_b = ht_reg;    end
            OP_INNOV: begin mul_req.op_a = h_reg;    mul_req.op_b = xp_reg;    end
            OP_EST:   begin mul_req.op_a = gain_reg; mul_req.op_b = innov_reg; end
            OP_IKH:   begin mul_req.op_a = gain_reg; mul_req.op_b = h_reg;     end
            OP_COV:   begin mul_req.op_a = tmp_reg;  mul_req.op_b = pp_reg;    end
            OP_PRED:  begin mul_req.op_a = a_reg;    mul_req.op_b = x_reg;     end
            OP_AP:    begin mul_req.op_a = a_reg;    mul_req.op_b = p_reg;     end
            OP_PPRED: begin mul_req.op_a = tmp_reg;  mul_req.op_b = at_reg;    end
            default:  begin mul_req.op_a = '0;       mul_req.op_b = '0;        end
        endcase
    end

    always_comb begin
        div_req.start = (state_reg == ST_DIVGO);
        div_req.num   = ppht_reg;
        div_req.den   = den_reg[skt_pkg::COV_W-1:0];
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_MUL;
                    step_next  = OP_PPHT;
                end
            end
            ST_MUL: begin
                state_next = ST_WB;
            end
            ST_WB: begin
                if (step_reg == OP_PPRED) begin
                    state_next = ST_FIN;
                end else begin
                    step_next = step_reg + 1'b1;
                    if ((step_reg == OP_INNOV) && den_pos) begin
                        state_next = ST_DIVGO;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_DIVGO: begin
                state_next = ST_DIVWAIT;
            end
            ST_DIVWAIT: begin
                if (!div_rsp.busy) begin
                    state_next = ST_MUL;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= OP_PPHT;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg  <= ONE;
            at_reg <= ONE;
            b_reg  <= '0;
            h_reg  <= ONE;
            ht_reg <= ONE;
            r_reg  <= ONE[skt_pkg::COV_W-1:0];
            q_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                skt_pkg::CFG_TRANS_GAIN:   a_reg  <= cfg_data;
                skt_pkg::CFG_TRANS_GAIN_T: at_reg <= cfg_data;
                skt_pkg::CFG_DRIFT_OFFSET: b_reg  <= cfg_data;
                skt_pkg::CFG_OBS_GAIN:     h_reg  <= cfg_data;
                skt_pkg::CFG_OBS_GAIN_T:   ht_reg <= cfg_data;
                skt_pkg::CFG_MEAS_NOISE:   r_reg  <= cfg_data[skt_pkg::COV_W-1:0];
                skt_pkg::CFG_PROC_NOISE:   q_reg  <= cfg_data[skt_pkg::COV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg  <= '0;
            xp_reg <= '0;
            p_reg  <= '0;
            pp_reg <= '0;
        end else if (accept) begin
            if (s_mode) begin
                x_reg  <= s_sample;
                xp_reg <= s_sample;
                p_reg  <= {1'b0, s_init_cov};
                pp_reg <= {1'b0, s_init_pred_cov};
            end
        end else if (state_reg == ST_WB) begin
            case (step_reg)
                OP_EST:   x_reg  <= skt_pkg::sat_add(mul_res, xp_reg);
                OP_COV:   p_reg  <= mul_res;
                OP_PRED:  xp_reg <= skt_pkg::sat_add(mul_res, b_reg);
                OP_PPRED: pp_reg <= skt_pkg::sat_add(mul_res, {1'b0, q_reg});
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            obs_reg <= s_sample;
        end
        if (state_reg == ST_WB) begin
            case (step_reg)
                OP_PPHT:  ppht_reg  <= mul_res;
                OP_HPP:   tmp_reg   <= mul_res;
                OP_DEN:   den_reg   <= skt_pkg::sat_add(mul_res, {1'b0, r_reg});
                OP_INNOV: begin
                    innov_reg <= skt_pkg::sat_sub(obs_reg, mul_res);
                    if (!den_pos) begin
                        gain_reg  <= '0;
                        fault_reg <= 1'b1;
                    end else begin
                        fault_reg <= 1'b0;
                    end
                end
                OP_IKH:   tmp_reg   <= skt_pkg::sat_sub(ONE, mul_res);
                OP_AP:    tmp_reg   <= mul_res;
                default: begin
                end
            endcase
        end
        if ((state_reg == ST_DIVWAIT) && !div_rsp.busy) begin
            gain_reg <= div_rsp.quot;
        end
    end

    always_comb begin
        if (fin_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fin_load) begin
            m_current_reg   <= x_reg;
            m_predicted_reg <= xp_reg;
            m_div_fault_reg <= fault_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_current   = m_current_reg;
    assign m_predicted = m_predicted_reg;
    assign m_div_fault = m_div_fault_reg;

endmodule

`default_nettype wire

[rtl/skt_mul.sv]
// Shared fixed-point multiplier: registered product, floor shift and saturation.
`timescale 1ns / 1ps
`default_nettype none

module skt_mul #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire skt_pkg::mul_req_t  req,
    output skt_pkg::data_t          res
);

    localparam int PROD_W = 2 * skt_pkg::DATA_W;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] shifted;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= req.op_a * req.op_b;
        end
    end

    always_comb begin
        shifted = prod_reg >>> FRAC_BITS;
        if (shifted[PROD_W-1:skt_pkg::DATA_W-1] !=
            {(PROD_W-skt_pkg::DATA_W+1){shifted[PROD_W-1]}}) begin
            res = shifted[PROD_W-1] ? skt_pkg::SAT_MIN : skt_pkg::SAT_MAX;
        end else begin
            res = shifted[skt_pkg::DATA_W-1:0];
        end
    end

endmodule

`default_nettype wire

[rtl/skt_div.sv]
// Radix-4 restoring divider for the gain quotient, truncating and saturating.
`timescale 1ns / 1ps
`default_nettype none

module skt_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire skt_pkg::div_req_t  req,
    output skt_pkg::div_rsp_t       rsp
);

    localparam int DW     = skt_pkg::DATA_W;
    localparam int RW     = skt_pkg::COV_W;
    localparam int NUM_W  = DW + FRAC_BITS;
    localparam int DIV_W  = NUM_W + (NUM_W % 2);
    localparam int ITER   = DIV_W / 2;
    localparam int CNT_W  = $clog2(ITER);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [RW-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [RW-1:0]    den_reg;
    logic             neg_reg;
    logic [DW-1:0]    mag;
    logic [DW:0]      trial;
    logic             hi_nz;

    assign mag = req.num[DW-1] ? (~req.num + 1'b1) : req.num;

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++) begin
            trial = {1'b0, rem_next, quo_next[DIV_W-1]};
            if (trial >= {2'b00, den_reg}) begin
                trial    = trial - {2'b00, den_reg};
                rem_next = trial[RW-1:0];
                quo_next = {quo_next[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[RW-1:0];
                quo_next = {quo_next[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ITER - 1);
        end else if (busy_reg) begin
            if (cnt_reg == '0) begin
                busy_reg <= 1'b0;
            end else begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= '0;
            quo_reg <= DIV_W'({mag, {FRAC_BITS{1'b0}}});
            den_reg <= req.den;
            neg_reg <= req.num[DW-1];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign hi_nz = |quo_reg[DIV_W-1:DW];

    always_comb begin
        rsp.busy = busy_reg;
        if (neg_reg) begin
            if (hi_nz || (quo_reg[DW-1] && (|quo_reg[DW-2:0]))) begin
                rsp.quot = skt_pkg::SAT_MIN;
            end else begin
                rsp.quot = ~quo_reg[DW-1:0] + 1'b1;
            end
        end else begin
            if (hi_nz || quo_reg[DW-1]) begin
                rsp.quot = skt_pkg::SAT_MAX;
            end else begin
                rsp.quot = quo_reg[DW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[rtl/skt_checker.sv]
// Port-level checks for the scalar Kalman tracker and their binding.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module skt_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [skt_pkg::DATA_W-1:0] m_current,
    input wire logic signed [skt_pkg::DATA_W-1:0] m_predicted,
    input wire logic                              m_div_fault
);

    // hold a stalled result
    `ASSERT_CLK(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_current) && $stable(m_predicted) && $stable(m_div_fault), "result changed while stalled")

    // drop ready once an item is taken
    `ASSERT_CLK(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready stayed high after an item")

    // a new result only comes out of an item in progress
    `ASSERT_CLK(a_result_from_work, $rose(m_valid) |-> $past(!s_ready), "result without work in progress")

    // come out of reset idle and empty
    `ASSERT_ANY(a_reset_idle, !aresetn |=> !m_valid && s_ready, "not idle after reset")

endmodule

bind scalar_kalman_tracker skt_checker u_skt_checker (.*);

`default_nettype wire
